/* rtl/bgd_pkg.sv */
// shared types and constants for the button gesture detector
`timescale 1ns / 1ps
package bgd_pkg;
   localparam int GESTURE_COUNT = 5;
   localparam int STEP_TOTAL = 14;
   localparam logic [3:0] COUNT_MAX = 4'd15;

   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_PERSIST = 2'd1;
   localparam logic [1:0] REG_MODE = 2'd2;

   typedef struct packed {
      logic [10:0] min_ms;
      logic [10:0] max_ms;
      logic        level;
   } seq_state_type;

   typedef struct packed {
      logic [3:0] first;
      logic [2:0] len;
   } seq_info_type;

   function automatic seq_state_type rom_state(input logic [3:0] idx);
      seq_state_type s;
      s = '{min_ms: 11'd0, max_ms: 11'd0, level: 1'b0};
      case (idx)
         4'd1:  s.level = 1'b1;
         4'd2:  s.level = 1'b1;
         4'd5:  begin s.level = 1'b1; s.min_ms = 11'd1000; end
         4'd7:  begin s.level = 1'b1; s.max_ms = 11'd999; end
         4'd10: begin s.level = 1'b1; s.max_ms = 11'd1999; end
         4'd11: s.max_ms = 11'd250;
         4'd12: begin s.level = 1'b1; s.max_ms = 11'd1999; end
         default: s = s;
      endcase
      return s;
   endfunction

   function automatic seq_info_type rom_info(input logic [2:0] g);
      seq_info_type r;
      case (g)
         3'd0:    r = '{first: 4'd0, len: 3'd2};
         3'd1:    r = '{first: 4'd2, len: 3'd2};
         3'd2:    r = '{first: 4'd4, len: 3'd2};
         3'd3:    r = '{first: 4'd6, len: 3'd3};
         default: r = '{first: 4'd9, len: 3'd5};
      endcase
      return r;
   endfunction
endpackage

/* rtl/button_gesture_detector.sv */
// button gesture detector top level
// Polls arrive on the req_ channel (button_level, time_ms), one result beat
// per poll leaves on the rsp_ channel (event_mask, event_time_ms).
// A poll runs through a small sequencer: a log step debounces and shifts the
// level log, then each of the five gestures is armed, walked one sequence
// state at a time through the shared adder/compare logic, and committed.
// After the last gesture commits, the result beat is held on rsp_ until it
// is taken, and the sequencer returns to idle before the next poll is taken.
// req_ready is low while a poll is in work and while a result beat waits.
// If the receiver stalls, the result holds on rsp_ and no new poll is taken.
// Reset clears the log, the counters, the repeat stamps and restores the
// registers to debounce 10 ms, persist delay 50 ms, event mode 0.
// Registers: 0x0 debounce_ms, 0x4 persist_delay_ms, 0x8 event_mode.
`timescale 1ns / 1ps
module button_gesture_detector #(
   parameter int LOG_DEPTH = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_button_level,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_event_mask,
   output logic [31:0] rsp_event_time_ms,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int LW = $clog2(LOG_DEPTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOG = 3'd1;
   localparam logic [2:0] ST_ARM = 3'd2;
   localparam logic [2:0] ST_CMP = 3'd3;
   localparam logic [2:0] ST_UPD = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [15:0] debounce_ff, debounce_in;
   logic [15:0] persist_ff, persist_in;
   logic [4:0]  mode_ff, mode_in;
   logic        lvl_ff [LOG_DEPTH];
   logic [31:0] tim_ff [LOG_DEPTH];
   logic        lvl_in [LOG_DEPTH];
   logic [31:0] tim_in [LOG_DEPTH];
   logic [3:0]  cnt_ff [bgd_pkg::GESTURE_COUNT];
   logic [3:0]  cnt_in [bgd_pkg::GESTURE_COUNT];
   logic [31:0] rep_ff [bgd_pkg::GESTURE_COUNT];
   logic [31:0] rep_in [bgd_pkg::GESTURE_COUNT];
   logic        level_ff, level_in;
   logic [31:0] now_ff, now_in;
   logic [2:0]  g_ff, g_in;
   logic [2:0]  k_ff, k_in;
   logic        ok_ff, ok_in;
   logic [4:0]  mask_ff, mask_in;

   bgd_pkg::seq_info_type  info;
   bgd_pkg::seq_state_type st;
   logic [LW-1:0] kidx, kprev;
   logic [31:0]   ts, later, sum_a, sum_b, dif;
   logic          armed, lvl_ok, k_in_log;
   logic          wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_event_mask = mask_ff;
   assign rsp_event_time_ms = now_ff;

   always_comb begin
      case (paddr[3:2])
         bgd_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_ff};
         bgd_pkg::REG_PERSIST:  prdata = {16'd0, persist_ff};
         bgd_pkg::REG_MODE:     prdata = {27'd0, mode_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign info = bgd_pkg::rom_info(g_ff);
   assign st = bgd_pkg::rom_state(info.first + {1'b0, info.len - 3'd1 - k_ff});
   assign k_in_log = ({29'd0, k_ff} < 32'(LOG_DEPTH));
   assign kidx = k_in_log ? LW'(k_ff) : '0;
   assign kprev = (k_ff == 3'd0 || !k_in_log) ? '0 : LW'(k_ff - 3'd1);
   assign ts = tim_ff[kidx];
   assign later = tim_ff[kprev];
   // shared unit: two adds for the min and max bounds, and the compares
   assign sum_a = ts + {21'd0, st.min_ms};
   assign sum_b = ts + {21'd0, st.max_ms};
   assign dif = now_ff - rep_ff[g_ff];
   assign lvl_ok = (st.level == lvl_ff[kidx]);
   assign armed = ({1'b0, cnt_ff[g_ff]} >= {2'b0, info.len}) ||
                  (mode_ff[g_ff] && dif >= {16'd0, persist_ff});

   always_comb begin
      state_in = state_ff;
      debounce_in = debounce_ff;
      persist_in = persist_ff;
      mode_in = mode_ff;
      lvl_in = lvl_ff;
      tim_in = tim_ff;
      cnt_in = cnt_ff;
      rep_in = rep_ff;
      level_in = level_ff;
      now_in = now_ff;
      g_in = g_ff;
      k_in = k_ff;
      ok_in = ok_ff;
      mask_in = mask_ff;
      if (wr) begin
         case (paddr[3:2])
            bgd_pkg::REG_DEBOUNCE: debounce_in = pwdata[15:0];
            bgd_pkg::REG_PERSIST:  persist_in = pwdata[15:0];
            bgd_pkg::REG_MODE:     mode_in = pwdata[4:0];
            default:               mode_in = mode_ff;
         endcase
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               level_in = req_button_level;
               now_in = req_time_ms;
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            if ((level_ff != lvl_ff[0] && (now_ff - tim_ff[0]) >= {16'd0, debounce_ff})
                || tim_ff[0] == 32'd0) begin
               for (int i = 1; i < LOG_DEPTH; i++) begin
                  lvl_in[i] = lvl_ff[i-1];
                  tim_in[i] = tim_ff[i-1];
               end
               lvl_in[0] = level_ff;
               tim_in[0] = now_ff;
               for (int j = 0; j < bgd_pkg::GESTURE_COUNT; j++)
                  if (cnt_ff[j] < bgd_pkg::COUNT_MAX) cnt_in[j] = cnt_ff[j] + 4'd1;
            end
            g_in = 3'd0;
            mask_in = 5'd0;
            state_in = ST_ARM;
         end
         ST_ARM: begin
            k_in = 3'd0;
            ok_in = armed;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!k_in_log || !lvl_ok) ok_in = 1'b0;
            else if (k_ff == 3'd0) begin
               if (sum_a > now_ff) ok_in = 1'b0;
            end else begin
               if (sum_a >= later) ok_in = 1'b0;
               if (st.max_ms != 11'd0 && sum_b <= later) ok_in = 1'b0;
            end
            k_in = k_ff + 3'd1;
            if (k_ff + 3'd1 == info.len) state_in = ST_UPD;
         end
         ST_UPD: begin
            if (ok_ff) begin
               mask_in[g_ff] = 1'b1;
               if (cnt_ff[g_ff] == 4'd0 && mode_ff[g_ff]) rep_in[g_ff] = now_ff;
               cnt_in[g_ff] = (g_ff == 3'd3) ? 4'd1 : 4'd0;
            end
            g_in = g_ff + 3'd1;
            state_in = (g_ff == 3'(bgd_pkg::GESTURE_COUNT - 1)) ? ST_OUT : ST_ARM;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         debounce_ff <= 16'd10;
         persist_ff <= 16'd50;
         mode_ff <= 5'd0;
         for (int i = 0; i < LOG_DEPTH; i++) begin
            lvl_ff[i] <= 1'b0;
            tim_ff[i] <= 32'd0;
         end
         for (int j = 0; j < bgd_pkg::GESTURE_COUNT; j++) begin
            cnt_ff[j] <= 4'd0;
            rep_ff[j] <= 32'd0;
         end
      end else begin
         state_ff <= state_in;
         debounce_ff <= debounce_in;
         persist_ff <= persist_in;
         mode_ff <= mode_in;
         lvl_ff <= lvl_in;
         tim_ff <= tim_in;
         cnt_ff <= cnt_in;
         rep_ff <= rep_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      now_ff <= now_in;
      g_ff <= g_in;
      k_ff <= k_in;
      ok_ff <= ok_in;
      mask_ff <= mask_in;
   end
endmodule
